FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the keyframe track sampler.
// No dependencies; simulation builds get the checks, synthesis gets empty text.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KTS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("kts assertion failed");
`define KTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kts assertion failed");
`else
`define KTS_ASSERT(label, clk, rst_n, prop)
`define KTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/kts_pkg.sv
// Shared types and constants of the keyframe track sampler.
// No dependencies.
package kts_pkg;
  localparam int DATA_W = 32;
  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int PADDR_W = 4;

  typedef logic signed [MUL_W-1:0]  mul_op_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  localparam logic [1:0] REG_INTERP_MODE     = 2'd0;
  localparam logic [1:0] REG_COMPONENT_COUNT = 2'd1;
  localparam logic [1:0] REG_KEY_COUNT       = 2'd2;

  localparam logic [1:0] MODE_STEP   = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_CUBIC  = 2'd2;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;
endpackage

FILE: rtl/kts_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module kts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/keyframe_track_sampler.sv
// Keyframe track sampler top level: config registers, key stores, sequencer.
// Depends on kts_pkg, kts_ram and assert_macros.svh.
//
// Usage: one animation track of up to MAX_KEYS keys, MAX_COMPONENTS components.
// Requests enter on start while busy is low. A load request (in_func = 0)
// writes the key time and one component's tangents and value in the cycle it
// is accepted and gives no result; busy stays low. A sample request
// (in_func = 1) on a track with keys raises busy and a small sequencer runs
// the search and the arithmetic on one shared 34x34 multiplier and a
// one-bit-per-cycle divider. The result appears on the out_ ports for exactly
// one cycle with out_valid; the receiver cannot stall, so the result is
// simply dropped if not taken. Busy falls in the cycle out_valid is shown, so
// a new request may be taken then. An empty track gives zeros without a search
// and without raising busy. A clamped sample, or a step sample after the binary
// search, copies the key values; a linear sample also divides for u and then
// does one multiply per component; a cubic sample divides, builds the Hermite
// basis on the multiplier and does four multiplies per component. The division
// is skipped at zero spacing. The time store read port paces the search and
// the shared multiplier the per-component work. Reset returns the registers to
// linear mode, 3 components, 0 keys; the key stores keep their contents.
`include "assert_macros.svh"

module keyframe_track_sampler
  import kts_pkg::*;
#(
  parameter int MAX_KEYS       = 64,
  parameter int MAX_COMPONENTS = 4,
  parameter int FRAC_BITS      = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                start,
  output logic                busy,
  input  logic                in_func,
  input  logic [5:0]          in_key_index,
  input  logic [1:0]          in_component,
  input  logic [31:0]         in_key_time,
  input  logic signed [31:0]  in_in_tangent,
  input  logic signed [31:0]  in_key_value,
  input  logic signed [31:0]  in_out_tangent,
  input  logic [31:0]         in_sample_time,
  // result channel
  output logic                out_valid,
  output logic signed [31:0]  out_result_0,
  output logic signed [31:0]  out_result_1,
  output logic signed [31:0]  out_result_2,
  output logic signed [31:0]  out_result_3,
  output logic [5:0]          out_key_found,
  output logic                out_saturated,
  // config port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  localparam int KW    = $clog2(MAX_KEYS);
  localparam int CW    = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int SW    = KW + CW;
  localparam int SLOTS = MAX_KEYS * (2 ** CW);
  localparam int NW    = $clog2(MAX_KEYS + 1);
  localparam int DCW   = $clog2(FRAC_BITS);

  localparam prod_t   HALF_P = prod_t'(1) <<< (FRAC_BITS - 1);
  localparam acc_t    HALF_A = acc_t'(1) <<< (FRAC_BITS - 1);
  localparam mul_op_t ONE_M  = mul_op_t'(1) <<< FRAC_BITS;
  localparam acc_t    SAT_HI = (acc_t'(1) <<< 31) - acc_t'(1);
  localparam acc_t    SAT_LO = -(acc_t'(1) <<< 31);

  // sequencer states
  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_RD_FIRST = 5'd1;
  localparam logic [4:0] ST_RD_LAST  = 5'd2;
  localparam logic [4:0] ST_CHECK    = 5'd3;
  localparam logic [4:0] ST_SRCH     = 5'd4;
  localparam logic [4:0] ST_SCMP     = 5'd5;
  localparam logic [4:0] ST_VAL      = 5'd6;
  localparam logic [4:0] ST_VCAP     = 5'd7;
  localparam logic [4:0] ST_TK0      = 5'd8;
  localparam logic [4:0] ST_TK1      = 5'd9;
  localparam logic [4:0] ST_DIVSET   = 5'd10;
  localparam logic [4:0] ST_DIV      = 5'd11;
  localparam logic [4:0] ST_PMUL     = 5'd12;
  localparam logic [4:0] ST_PACC     = 5'd13;
  localparam logic [4:0] ST_CRD      = 5'd14;
  localparam logic [4:0] ST_CRD2     = 5'd15;
  localparam logic [4:0] ST_CRD3     = 5'd16;
  localparam logic [4:0] ST_CMUL     = 5'd17;
  localparam logic [4:0] ST_CACC     = 5'd18;
  localparam logic [4:0] ST_CFIN     = 5'd19;

  // config registers
  logic [1:0] interp_r, interp_nxt;
  logic [2:0] ccount_r, ccount_nxt;
  logic [6:0] kcount_r, kcount_nxt;

  // sequencer registers
  logic [4:0]          state_r, state_nxt;
  logic [31:0]         t_r, t_nxt;
  logic [NW-1:0]       n_r, n_nxt;
  logic [2:0]          comps_r, comps_nxt;
  logic                step_r, step_nxt;
  logic                cubic_r, cubic_nxt;
  logic [KW-1:0]       lo_r, lo_nxt, hi_r, hi_nxt, k_r, k_nxt;
  logic                clamp_r, clamp_nxt;
  logic [31:0]         tfirst_r, tfirst_nxt, t0_r, t0_nxt, rem_r, rem_nxt;
  logic signed [32:0]  dt_r, dt_nxt;
  logic [FRAC_BITS-1:0] u_r, u_nxt;
  logic [DCW-1:0]      cnt_r, cnt_nxt;
  logic [1:0]          op_r, op_nxt, c_r, c_nxt;
  mul_op_t             u2_r, u2_nxt, u3_r, u3_nxt;
  mul_op_t             c0_r, c0_nxt, c1_r, c1_nxt, c2_r, c2_nxt, c3_r, c3_nxt;
  mul_op_t             s1_r, s1_nxt, s3_r, s3_nxt;
  logic signed [31:0]  va_r, va_nxt, oa_r, oa_nxt, vb_r, vb_nxt, ib_r, ib_nxt;
  prod_t               prod_r, prod_nxt;
  acc_t                acc_r, acc_nxt;
  logic signed [31:0]  res_r [4];
  logic signed [31:0]  res_nxt [4];
  logic                sat_r, sat_nxt;
  logic                out_valid_r, out_valid_nxt;

  // combinational helpers
  logic                accept, cfg_we, load_we;
  logic [31:0]         kc_wide, ki_wide, k_wide;
  logic [NW-1:0]       n_sel;
  logic [KW-1:0]       nm1, k1, mid, w_key;
  logic [KW:0]         lo_inc, lo_hi_sum;
  logic [SW-1:0]       w_slot, slot_k, slot_k1, v_raddr;
  logic [KW-1:0]       t_raddr;
  logic [31:0]         t_rdata, v_rdata, o_rdata, i_rdata;
  mul_op_t             mul_a, mul_b, u_ext, rp_m, u3_new;
  prod_t               rp;
  acc_t                ra, acc_base;
  logic signed [32:0]  vdiff;
  logic [32:0]         rem2, dz;
  logic                div_ge, last_comp;
  logic [31:0]         diff, dspan;
  logic [1:0]          last_op;
  logic [4:0]          after_div;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign pready    = 1'b1;
  assign cfg_we    = psel && penable && pwrite;

  // ---------------- config port ----------------
  always_comb begin
    interp_nxt = interp_r;
    ccount_nxt = ccount_r;
    kcount_nxt = kcount_r;
    if (cfg_we) begin
      unique case (paddr[3:2])
        REG_INTERP_MODE:     interp_nxt = pwdata[1:0];
        REG_COMPONENT_COUNT: ccount_nxt = pwdata[2:0];
        REG_KEY_COUNT:       kcount_nxt = pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_INTERP_MODE:     prdata = {30'd0, interp_r};
      REG_COMPONENT_COUNT: prdata = {29'd0, ccount_r};
      REG_KEY_COUNT:       prdata = {25'd0, kcount_r};
      default:             prdata = 32'd0;
    endcase
  end

  // ---------------- key stores ----------------
  // loads are written straight from the request ports; out-of-range slots drop
  assign ki_wide = 32'(in_key_index);
  assign w_key   = ki_wide[KW-1:0];
  assign w_slot  = {w_key, in_component[CW-1:0]};
  assign load_we = accept && (in_func == FUNC_LOAD) &&
                   (ki_wide < 32'(MAX_KEYS)) && (32'(in_component) < 32'(MAX_COMPONENTS));

  assign k1      = k_r + KW'(1);
  assign slot_k  = {k_r, c_r[CW-1:0]};
  assign slot_k1 = {k1, c_r[CW-1:0]};
  assign v_raddr = (state_r == ST_CRD2) ? slot_k1 : slot_k;

  kts_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_time_ram (
    .clk(clk), .we(load_we), .waddr(w_key), .wdata(in_key_time),
    .raddr(t_raddr), .rdata(t_rdata)
  );
  kts_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_value_ram (
    .clk(clk), .we(load_we), .waddr(w_slot), .wdata(in_key_value),
    .raddr(v_raddr), .rdata(v_rdata)
  );
  kts_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_out_tan_ram (
    .clk(clk), .we(load_we), .waddr(w_slot), .wdata(in_out_tangent),
    .raddr(slot_k), .rdata(o_rdata)
  );
  kts_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_in_tan_ram (
    .clk(clk), .we(load_we), .waddr(w_slot), .wdata(in_in_tangent),
    .raddr(slot_k1), .rdata(i_rdata)
  );

  // ---------------- search helpers ----------------
  assign kc_wide   = 32'(kcount_r);
  assign n_sel     = (kc_wide > 32'(MAX_KEYS)) ? NW'(MAX_KEYS) : NW'(kc_wide);
  assign nm1       = KW'(n_r - NW'(1));
  assign lo_inc    = {1'b0, lo_r} + (KW+1)'(1);
  assign lo_hi_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = lo_hi_sum[KW:1];

  always_comb begin
    unique case (state_r)
      ST_RD_LAST: t_raddr = nm1;
      ST_SRCH:    t_raddr = mid;
      ST_TK0:     t_raddr = k_r;
      ST_TK1:     t_raddr = k1;
      default:    t_raddr = '0;
    endcase
  end

  // ---------------- shared multiplier ----------------
  assign u_ext = $signed({{(MUL_W-FRAC_BITS){1'b0}}, u_r});
  assign vdiff = 33'(vb_r) - 33'(va_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_PMUL) begin
      unique case (op_r)
        2'd0: begin mul_a = u_ext; mul_b = u_ext; end
        2'd1: begin mul_a = u2_r;  mul_b = u_ext; end
        2'd2: begin mul_a = c1_r;  mul_b = MUL_W'(dt_r); end
        default: begin mul_a = c3_r; mul_b = MUL_W'(dt_r); end
      endcase
    end else if (state_r == ST_CMUL) begin
      if (cubic_r) begin
        unique case (op_r)
          2'd0: begin mul_a = c0_r; mul_b = MUL_W'(va_r); end
          2'd1: begin mul_a = s1_r; mul_b = MUL_W'(oa_r); end
          2'd2: begin mul_a = c2_r; mul_b = MUL_W'(vb_r); end
          default: begin mul_a = s3_r; mul_b = MUL_W'(ib_r); end
        endcase
      end else begin
        mul_a = u_ext;
        mul_b = MUL_W'(vdiff);
      end
    end
  end

  assign prod_nxt = mul_a * mul_b;

  // round half up, then back to operand width
  assign rp     = (prod_r + HALF_P) >>> FRAC_BITS;
  assign rp_m   = rp[MUL_W-1:0];
  assign u3_new = rp_m;
  assign ra     = (acc_r + HALF_A) >>> FRAC_BITS;

  assign last_op  = cubic_r ? 2'd3 : 2'd0;
  assign acc_base = (op_r != 2'd0) ? acc_r :
                    (cubic_r ? acc_t'(0) : (ACC_W'(va_r) <<< FRAC_BITS));

  // ---------------- divider step ----------------
  assign rem2   = {rem_r, 1'b0};
  assign dz     = {1'b0, dt_r[31:0]};
  assign div_ge = (rem2 >= dz);
  assign diff   = t_r - t0_r;
  assign dspan  = t_rdata - t0_r;

  assign after_div = cubic_r ? ST_PMUL : ST_CRD;
  assign last_comp = ({1'b0, c_r} == (comps_r - 3'd1));

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt     = state_r;
    t_nxt         = t_r;
    n_nxt         = n_r;
    comps_nxt     = comps_r;
    step_nxt      = step_r;
    cubic_nxt     = cubic_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    k_nxt         = k_r;
    clamp_nxt     = clamp_r;
    tfirst_nxt    = tfirst_r;
    t0_nxt        = t0_r;
    rem_nxt       = rem_r;
    dt_nxt        = dt_r;
    u_nxt         = u_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    c_nxt         = c_r;
    u2_nxt        = u2_r;
    u3_nxt        = u3_r;
    c0_nxt        = c0_r;
    c1_nxt        = c1_r;
    c2_nxt        = c2_r;
    c3_nxt        = c3_r;
    s1_nxt        = s1_r;
    s3_nxt        = s3_r;
    va_nxt        = va_r;
    oa_nxt        = oa_r;
    vb_nxt        = vb_r;
    ib_nxt        = ib_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    sat_nxt       = sat_r;
    out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_func == FUNC_SAMPLE) begin
          t_nxt     = in_sample_time;
          n_nxt     = n_sel;
          if (ccount_r == 3'd0) begin
            comps_nxt = 3'd1;
          end else if (32'(ccount_r) > 32'(MAX_COMPONENTS)) begin
            comps_nxt = 3'(MAX_COMPONENTS);
          end else begin
            comps_nxt = ccount_r;
          end
          step_nxt  = (interp_r == MODE_STEP);
          cubic_nxt = (interp_r == MODE_CUBIC);
          k_nxt     = '0;
          c_nxt     = 2'd0;
          op_nxt    = 2'd0;
          sat_nxt   = 1'b0;
          for (int i = 0; i < 4; i++) begin
            res_nxt[i] = '0;
          end
          if (n_sel == '0) begin
            out_valid_nxt = 1'b1;   // empty track: zeros right away
          end else begin
            state_nxt = ST_RD_FIRST;
          end
        end
      end
      ST_RD_FIRST: state_nxt = ST_RD_LAST;
      ST_RD_LAST: begin
        tfirst_nxt = t_rdata;
        state_nxt  = ST_CHECK;
      end
      ST_CHECK: begin
        // t_rdata holds the last key time here
        if (n_r == NW'(1) || t_r <= tfirst_r) begin
          k_nxt     = '0;
          clamp_nxt = 1'b1;
          state_nxt = ST_VAL;
        end else if (t_r >= t_rdata) begin
          k_nxt     = nm1;
          clamp_nxt = 1'b1;
          state_nxt = ST_VAL;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = nm1;
          clamp_nxt = step_r;
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (lo_inc < {1'b0, hi_r}) begin
          state_nxt = ST_SCMP;
        end else begin
          k_nxt     = lo_r;
          state_nxt = clamp_r ? ST_VAL : ST_TK0;
        end
      end
      ST_SCMP: begin
        if (t_rdata <= t_r) begin
          lo_nxt = mid;
        end else begin
          hi_nxt = mid;
        end
        state_nxt = ST_SRCH;
      end
      ST_VAL: state_nxt = ST_VCAP;
      ST_VCAP: begin
        res_nxt[c_r] = v_rdata;
        if (last_comp) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          c_nxt     = c_r + 2'd1;
          state_nxt = ST_VAL;
        end
      end
      ST_TK0: state_nxt = ST_TK1;
      ST_TK1: begin
        t0_nxt    = t_rdata;
        state_nxt = ST_DIVSET;
      end
      ST_DIVSET: begin
        dt_nxt  = 33'(t_rdata) - 33'(t0_r);
        u_nxt   = '0;
        cnt_nxt = '0;
        op_nxt  = 2'd0;
        if (t_rdata > t0_r && t_r >= t0_r) begin
          if (diff >= dspan) begin
            u_nxt     = '1;          // u limited just below one
            state_nxt = after_div;
          end else begin
            rem_nxt   = diff;
            state_nxt = ST_DIV;
          end
        end else begin
          state_nxt = after_div;     // zero or inverted spacing: u = 0
        end
      end
      ST_DIV: begin
        rem_nxt = div_ge ? 32'(rem2 - dz) : rem2[31:0];
        u_nxt   = {u_r[FRAC_BITS-2:0], div_ge};
        if (cnt_r == DCW'(FRAC_BITS - 1)) begin
          state_nxt = after_div;
        end else begin
          cnt_nxt = cnt_r + DCW'(1);
        end
      end
      ST_PMUL: state_nxt = ST_PACC;
      ST_PACC: begin
        unique case (op_r)
          2'd0: u2_nxt = rp_m;
          2'd1: begin
            u3_nxt = u3_new;
            c0_nxt = (u3_new <<< 1) - u2_r - (u2_r <<< 1) + ONE_M;
            c1_nxt = u3_new - (u2_r <<< 1) + u_ext;
            c2_nxt = u2_r + (u2_r <<< 1) - (u3_new <<< 1);
            c3_nxt = u3_new - u2_r;
          end
          2'd2: s1_nxt = rp_m;
          default: s3_nxt = rp_m;
        endcase
        if (op_r == 2'd3) begin
          op_nxt    = 2'd0;
          state_nxt = ST_CRD;
        end else begin
          op_nxt    = op_r + 2'd1;
          state_nxt = ST_PMUL;
        end
      end
      ST_CRD: state_nxt = ST_CRD2;
      ST_CRD2: begin
        va_nxt    = v_rdata;
        oa_nxt    = o_rdata;
        state_nxt = ST_CRD3;
      end
      ST_CRD3: begin
        vb_nxt    = v_rdata;
        ib_nxt    = i_rdata;
        op_nxt    = 2'd0;
        state_nxt = ST_CMUL;
      end
      ST_CMUL: state_nxt = ST_CACC;
      ST_CACC: begin
        acc_nxt = acc_base + ACC_W'(prod_r);
        if (op_r == last_op) begin
          state_nxt = ST_CFIN;
        end else begin
          op_nxt    = op_r + 2'd1;
          state_nxt = ST_CMUL;
        end
      end
      ST_CFIN: begin
        if (ra > SAT_HI) begin
          res_nxt[c_r] = 32'sh7fffffff;
          sat_nxt      = 1'b1;
        end else if (ra < SAT_LO) begin
          res_nxt[c_r] = 32'sh80000000;
          sat_nxt      = 1'b1;
        end else begin
          res_nxt[c_r] = ra[31:0];
        end
        op_nxt = 2'd0;
        if (last_comp) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          c_nxt     = c_r + 2'd1;
          state_nxt = ST_CRD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      interp_r    <= MODE_LINEAR;
      ccount_r    <= 3'd3;
      kcount_r    <= 7'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      interp_r    <= interp_nxt;
      ccount_r    <= ccount_nxt;
      kcount_r    <= kcount_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r      <= t_nxt;
    n_r      <= n_nxt;
    comps_r  <= comps_nxt;
    step_r   <= step_nxt;
    cubic_r  <= cubic_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    k_r      <= k_nxt;
    clamp_r  <= clamp_nxt;
    tfirst_r <= tfirst_nxt;
    t0_r     <= t0_nxt;
    rem_r    <= rem_nxt;
    dt_r     <= dt_nxt;
    u_r      <= u_nxt;
    cnt_r    <= cnt_nxt;
    op_r     <= op_nxt;
    c_r      <= c_nxt;
    u2_r     <= u2_nxt;
    u3_r     <= u3_nxt;
    c0_r     <= c0_nxt;
    c1_r     <= c1_nxt;
    c2_r     <= c2_nxt;
    c3_r     <= c3_nxt;
    s1_r     <= s1_nxt;
    s3_r     <= s3_nxt;
    va_r     <= va_nxt;
    oa_r     <= oa_nxt;
    vb_r     <= vb_nxt;
    ib_r     <= ib_nxt;
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
    res_r    <= res_nxt;
    sat_r    <= sat_nxt;
  end

  // ---------------- result ports ----------------
  assign k_wide        = 32'(k_r);
  assign out_valid     = out_valid_r;
  assign out_result_0  = res_r[0];
  assign out_result_1  = res_r[1];
  assign out_result_2  = res_r[2];
  assign out_result_3  = res_r[3];
  assign out_key_found = k_wide[5:0];
  assign out_saturated = sat_r;

  // ---------------- checks ----------------
  `KTS_ASSERT(a_strobe_when_idle, clk, rst_n, out_valid |-> !busy)
  `KTS_ASSERT_NEXT(a_load_no_result, clk, rst_n, accept && in_func == FUNC_LOAD, !out_valid)
  `KTS_ASSERT(a_busy_from_request, clk, rst_n, $rose(busy) |-> $past(start))
endmodule

FILE: tb/keyframe_track_sampler_tb.sv
// Testbench for the keyframe track sampler: load and sample requests with an
// internal fixed-point predictor of step, linear and cubic Hermite sampling.
// Depends on kts_pkg and the keyframe_track_sampler RTL.
module keyframe_track_sampler_tb;
  import kts_pkg::*;

  typedef struct packed {
    logic signed [31:0] r0;
    logic signed [31:0] r1;
    logic signed [31:0] r2;
    logic signed [31:0] r3;
    logic [5:0]         key;
    logic               sat;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_func = FUNC_LOAD;
  logic [5:0] in_key_index = '0;
  logic [1:0] in_component = '0;
  logic [31:0] in_key_time = '0;
  logic signed [31:0] in_in_tangent = '0;
  logic signed [31:0] in_key_value = '0;
  logic signed [31:0] in_out_tangent = '0;
  logic [31:0] in_sample_time = '0;
  logic out_valid;
  logic signed [31:0] out_result_0, out_result_1, out_result_2, out_result_3;
  logic [5:0] out_key_found;
  logic out_saturated;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Predictor state: key stores and the three registers.
  logic [31:0]        time_mem [64];
  logic signed [31:0] val_mem  [256];
  logic signed [31:0] tin_mem  [256];
  logic signed [31:0] tout_mem [256];
  logic [1:0] mode_reg = MODE_LINEAR;
  logic [2:0] comp_reg = 3'd3;
  logic [6:0] kcnt_reg = 7'd0;

  sample_t pending_samples[$];
  int errors = 0;
  bit idle_on = 1'b1;

  always #5 clk = ~clk;

  keyframe_track_sampler dut (
    .clk, .rst_n, .start, .busy, .in_func, .in_key_index, .in_component,
    .in_key_time, .in_in_tangent, .in_key_value, .in_out_tangent,
    .in_sample_time, .out_valid, .out_result_0, .out_result_1, .out_result_2,
    .out_result_3, .out_key_found, .out_saturated, .psel, .penable, .pwrite,
    .paddr, .pwdata, .prdata, .pready
  );

  // Watchdog: the slowest legal run is far below this.
  initial begin
    #30_000_000;
    $display("keyframe_track_sampler_tb: errors");
    $finish;
  end

  // Scale a Q-product back by 16 fraction bits, rounding half up.
  function automatic longint rnd16(longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [31:0] clip(longint v, inout logic flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Lower key by binary search: last key with time at or below t, else 0.
  function automatic int lower_key(int n, logic [31:0] t);
    int lo, hi, mid;
    lo = 0;
    hi = n - 1;
    if (n == 0 || t <= time_mem[0]) return 0;
    if (t >= time_mem[n-1]) return n - 1;
    while (lo + 1 < hi) begin
      mid = lo + (hi - lo) / 2;
      if (time_mem[mid] <= t) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic sample_t predict_sample(logic [31:0] t);
    int n, comps, k, k1;
    logic [1:0] m;
    bit clamp;
    logic flag;
    longint dt, u, u2, u3, c0, c1, c2, c3, s1, s3, acc, a, b;
    longint unsigned num;
    logic signed [31:0] res [4];
    sample_t r;
    n = (kcnt_reg > 64) ? 64 : kcnt_reg;
    comps = (comp_reg == 0) ? 1 : ((comp_reg > 4) ? 4 : comp_reg);
    m = (mode_reg == 2'd3) ? MODE_LINEAR : mode_reg;
    flag = 1'b0;
    k = 0;
    foreach (res[i]) res[i] = '0;
    if (n > 0) begin
      clamp = 1'b1;
      if (m == MODE_STEP) k = lower_key(n, t);
      else if (n == 1 || t <= time_mem[0]) k = 0;
      else if (t >= time_mem[n-1]) k = n - 1;
      else begin
        k = lower_key(n, t);
        clamp = 1'b0;
      end
      if (clamp) begin
        for (int c = 0; c < comps; c++) res[c] = val_mem[k*4+c];
      end else begin
        k1 = k + 1;
        dt = longint'({32'b0, time_mem[k1]}) - longint'({32'b0, time_mem[k]});
        u = 0;
        // zero or inverted spacing leaves u at zero
        if (dt > 0 && t >= time_mem[k]) begin
          num = {32'b0, t - time_mem[k]} << 16;
          u = longint'(num / longint'(dt));
          if (u > 65535) u = 65535;
        end
        if (m == MODE_CUBIC) begin
          u2 = rnd16(u * u);
          u3 = rnd16(u2 * u);
          c0 = 2 * u3 - 3 * u2 + 65536;
          c1 = u3 - 2 * u2 + u;
          c2 = -2 * u3 + 3 * u2;
          c3 = u3 - u2;
          s1 = rnd16(c1 * dt);
          s3 = rnd16(c3 * dt);
          for (int c = 0; c < comps; c++) begin
            acc = c0 * longint'(val_mem[k*4+c]) + s1 * longint'(tout_mem[k*4+c])
                + c2 * longint'(val_mem[k1*4+c]) + s3 * longint'(tin_mem[k1*4+c]);
            res[c] = clip(rnd16(acc), flag);
          end
        end else begin
          for (int c = 0; c < comps; c++) begin
            a = val_mem[k*4+c];
            b = val_mem[k1*4+c];
            acc = a * 65536 + (b - a) * u;
            res[c] = clip(rnd16(acc), flag);
          end
        end
      end
    end
    r.r0 = res[0];
    r.r1 = res[1];
    r.r2 = res[2];
    r.r3 = res[3];
    r.key = k[5:0];
    r.sat = flag;
    return r;
  endfunction

  // Result checker: every strobe must match the oldest pending sample.
  always @(posedge clk) begin
    sample_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_result_0, out_result_1, out_result_2, out_result_3,
              out_key_found, out_saturated};
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_samples.pop_front();
        if (got.r0 !== want.r0 || got.r1 !== want.r1 || got.r2 !== want.r2 ||
            got.r3 !== want.r3) begin
          $display("%0t: results expected %h %h %h %h actual %h %h %h %h", $time,
                   want.r0, want.r1, want.r2, want.r3,
                   got.r0, got.r1, got.r2, got.r3);
          errors++;
        end
        if (got.key !== want.key) begin
          $display("%0t: key_found expected %0d actual %0d", $time, want.key, got.key);
          errors++;
        end
        if (got.sat !== want.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
          errors++;
        end
      end
    end
  end

  // One request; returns at the edge that accepts it, start still high.
  task automatic send_req(logic f, logic [5:0] ki, logic [1:0] ci, logic [31:0] kt,
                          logic [31:0] ti, logic [31:0] kv, logic [31:0] to,
                          logic [31:0] st);
    if (idle_on && $urandom_range(99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= f;
    in_key_index <= ki;
    in_component <= ci;
    in_key_time <= kt;
    in_in_tangent <= ti;
    in_key_value <= kv;
    in_out_tangent <= to;
    in_sample_time <= st;
    do @(posedge clk); while (busy);
    if (f == FUNC_LOAD) begin
      time_mem[ki] = kt;
      tin_mem[ki*4+ci] = ti;
      val_mem[ki*4+ci] = kv;
      tout_mem[ki*4+ci] = to;
    end else begin
      pending_samples.push_back(predict_sample(st));
    end
  endtask

  task automatic sample_at(logic [31:0] t);
    send_req(FUNC_SAMPLE, 6'($urandom), 2'($urandom), $urandom, $urandom, $urandom,
             $urandom, t);
  endtask

  task automatic load_comp(int k, int c, logic [31:0] kt, logic [31:0] ti,
                           logic [31:0] kv, logic [31:0] to);
    send_req(FUNC_LOAD, k[5:0], c[1:0], kt, ti, kv, to, $urandom);
  endtask

  // Values: mostly moderate, sometimes full range or at the extremes.
  function automatic logic [31:0] rand_val();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom;
      default: return $urandom_range(0, 32'h00ffffff) - 32'h00800000;
    endcase
  endfunction

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Register write while idle: setup cycle then access cycle.
  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= PADDR_W'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_INTERP_MODE:     mode_reg = value[1:0];
      REG_COMPONENT_COUNT: comp_reg = value[2:0];
      REG_KEY_COUNT:       kcnt_reg = value[6:0];
      default: ;
    endcase
  endtask

  // Loads n keys, all four components; times ascend by random gaps, with
  // occasional equal neighbors when dups is set.
  task automatic fill_track(int n, logic [31:0] first, int max_gap, bit dups);
    logic [31:0] t;
    t = first;
    for (int k = 0; k < n; k++) begin
      for (int c = 0; c < 4; c++) load_comp(k, c, t, rand_val(), rand_val(), rand_val());
      if (!(dups && $urandom_range(5) == 0)) t = t + $urandom_range(1, max_gap);
    end
  endtask

  task automatic set_track(int mode, int comps, int kc);
    cfg_write(REG_INTERP_MODE, mode);
    cfg_write(REG_COMPONENT_COUNT, comps);
    cfg_write(REG_KEY_COUNT, kc);
  endtask

  task automatic test_empty_track();
    sample_at(32'h0);
    sample_at(32'hffffffff);
  endtask

  task automatic test_directed();
    // three keys, in-range and clamped samples in every mode
    fill_track(3, 32'h0001_0000, 32'h0002_0000, 1'b0);
    for (int m = 0; m < 4; m++) begin
      set_track(m, (m == 3) ? 0 : 4, 3);
      sample_at(32'h0);
      sample_at(time_mem[0]);
      sample_at(time_mem[0] + 32'h8000);
      sample_at(time_mem[1]);
      sample_at(time_mem[2] - 1);
      sample_at(32'hffffffff);
    end
    // single key and component count above range
    set_track(MODE_CUBIC, 7, 1);
    sample_at(32'h1234_5678);
    // extreme values and tangents over a huge spacing to force clipping
    load_comp(0, 0, 32'h0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    load_comp(1, 0, 32'hffffffff, 32'h80000000, 32'h80000000, 32'h80000000);
    load_comp(0, 1, 32'h0, 32'h80000000, 32'h80000000, 32'h80000000);
    load_comp(1, 1, 32'hffffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    set_track(MODE_CUBIC, 2, 2);
    sample_at(32'h4000_0000);
    sample_at(32'hc000_0000);
    // zero spacing: both keys at the same time
    load_comp(1, 0, 32'h0, rand_val(), rand_val(), rand_val());
    load_comp(1, 1, 32'h0, rand_val(), rand_val(), rand_val());
    sample_at(32'h0);
  endtask

  task automatic test_random(int segments);
    int n, items;
    logic [31:0] t;
    for (int s = 0; s < segments; s++) begin
      idle_on = (s != 2);  // one segment runs back to back
      n = (s == 3) ? 64 : $urandom_range(2, 8);
      fill_track(n, $urandom_range(0, 32'h0004_0000), (s == 4) ? 32'h7fff_ffff / n
                 : 32'h0003_0000, s % 2);
      set_track($urandom_range(0, 3), $urandom_range(0, 7),
                (s == 3) ? 127 : $urandom_range(1, n));
      items = (s == 3) ? 30 : 20;
      for (int i = 0; i < items; i++) begin
        if ($urandom_range(99) < 12) begin
          // key reload; now and then with an out-of-order time
          n = $urandom_range(0, 7);
          t = ($urandom_range(3) == 0) ? $urandom : time_mem[n];
          load_comp(n, $urandom_range(0, 3), t, rand_val(), rand_val(), rand_val());
        end else begin
          case ($urandom_range(5))
            0: t = $urandom;
            1: t = time_mem[$urandom_range(0, 7)];
            default: t = time_mem[0] + $urandom_range(0, 32'h0010_0000);
          endcase
          sample_at(t);
        end
      end
    end
    idle_on = 1'b1;
  endtask

  // Sender holds off until every pending sample has come back.
  task automatic test_drain_pause();
    for (int i = 0; i < 5; i++) begin
      sample_at(time_mem[0] + $urandom_range(0, 32'h0008_0000));
      start <= 1'b0;
      @(posedge clk);
      while (pending_samples.size() != 0) @(posedge clk);
    end
  endtask

  initial begin
    // times of keys not yet loaded still serve as stimulus
    foreach (time_mem[i]) time_mem[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_track();
    test_directed();
    test_drain_pause();
    test_random(6);
    wait_drained();
    if (errors == 0) begin
      $display("keyframe_track_sampler_tb: clean");
    end else begin
      $display("keyframe_track_sampler_tb: errors");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/kts_pkg.sv
rtl/kts_ram.sv
rtl/keyframe_track_sampler.sv
tb/keyframe_track_sampler_tb.sv
